// ===== design/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the max priority queue
// no dependencies; used by mhpq_cell and max_heap_priority_queue

package mhpq_pkg;

	// key and count field widths
	localparam int KEY_W     = 32;
	localparam int ENTRIES_W = 8;
	localparam int DATA_IN_W  = 32;
	localparam int DATA_OUT_W = 40;

	// default number of cells
	localparam int CAPACITY_DEF = 128;

	// command codes carried on s_tuser
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// result status carried on m_tuser
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DROPPED   = 2'd1,
		ST_EXTRACTED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// broadcast control seen by every cell
	typedef struct packed {
		logic             ins;
		logic             ext;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

// ===== design/mhpq_cell.sv =====
`timescale 1ns / 1ps
// one cell of the sorted key row: holds one key, takes the new key or shifts right on insert, shifts left on extract
// depends on mhpq_pkg

module mhpq_cell (
	input  logic                             clk,
	input  mhpq_pkg::cell_ctrl_t             ctrl,
	input  logic                             vacant,
	input  logic                             left_goes,
	input  logic [mhpq_pkg::KEY_W-1:0]       left_key,
	input  logic [mhpq_pkg::KEY_W-1:0]       right_key,
	output logic                             goes,
	output logic [mhpq_pkg::KEY_W-1:0]       key
);

	logic [mhpq_pkg::KEY_W-1:0] key_q;

	// new key belongs at or before this cell
	always_comb begin
		goes = vacant || ($signed(ctrl.key) > $signed(key_q));
	end

	// on insert load the new key at the slot and shift right past it, shift left on extract
	always_ff @(posedge clk) begin
		if (ctrl.ins && goes) begin
			key_q <= left_goes ? left_key : ctrl.key;
		end else if (ctrl.ext) begin
			key_q <= right_key;
		end
	end

	assign key = key_q;

endmodule

// ===== design/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// Bounded max priority queue of signed 32-bit keys built as a row of CAPACITY cells kept
// sorted largest first. An insert is compared against every cell at once and the cells
// past its slot shift one place right; an extract takes cell zero and the row shifts left.
// The result is registered and appears on the master side in the cycle after the transfer,
// and a new item is taken every cycle while the output is drained. The clock cycle is set
// by the key compare in each cell plus the slot select between neighbors. Every item
// gives one result: status on m_tuser, key and entry count on m_tdata. Depends on mhpq_pkg
// and mhpq_cell.

module max_heap_priority_queue #(
	parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mhpq_pkg::DATA_IN_W-1:0]      s_tdata,   // [31:0] key_in
	input  logic                                s_tuser,   // [0] command
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mhpq_pkg::DATA_OUT_W-1:0]     m_tdata,   // [31:0] key_out, [39:32] entries
	output logic [1:0]                          m_tuser    // [1:0] status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              count_next;
	logic                          out_valid_q;
	mhpq_pkg::status_t             status_q;
	logic [mhpq_pkg::KEY_W-1:0]    key_out_q;
	logic [mhpq_pkg::ENTRIES_W-1:0] entries_q;

	logic                          accept;
	logic                          full;
	logic                          empty;
	mhpq_pkg::status_t             status_next;
	mhpq_pkg::cell_ctrl_t          ctrl;

	logic [CAPACITY-1:0]           cell_goes;
	logic [mhpq_pkg::KEY_W-1:0]    cell_key [CAPACITY];

	// input transfer while the output register is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// command decode and next count
	always_comb begin
		ctrl.key   = s_tdata[mhpq_pkg::KEY_W-1:0];
		ctrl.ins   = 1'b0;
		ctrl.ext   = 1'b0;
		count_next = count_q;
		if (s_tuser == mhpq_pkg::CMD_INSERT) begin
			if (full) begin
				status_next = mhpq_pkg::ST_DROPPED;
			end else begin
				status_next = mhpq_pkg::ST_INSERTED;
				ctrl.ins    = accept;
				count_next  = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_next = mhpq_pkg::ST_EMPTY;
			end else begin
				status_next = mhpq_pkg::ST_EXTRACTED;
				ctrl.ext    = accept;
				count_next  = count_q - CNT_W'(1);
			end
		end
	end

	// row of cells, largest key in cell zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                       vacant;
		logic                       left_goes;
		logic [mhpq_pkg::KEY_W-1:0] left_key;
		logic [mhpq_pkg::KEY_W-1:0] right_key;

		assign vacant = (count_q <= CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_goes = 1'b0;
			assign left_key  = '0;
		end else begin : g_mid
			assign left_goes = cell_goes[i-1];
			assign left_key  = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key = '0;
		end else begin : g_inner
			assign right_key = cell_key[i+1];
		end

		mhpq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.vacant    (vacant),
			.left_goes (left_goes),
			.left_key  (left_key),
			.right_key (right_key),
			.goes      (cell_goes[i]),
			.key       (cell_key[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_next;
			key_out_q <= (status_next == mhpq_pkg::ST_EXTRACTED) ? cell_key[0] : '0;
			entries_q <= mhpq_pkg::ENTRIES_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {entries_q, key_out_q};

`ifndef NO_ASSERTIONS
	// count never passes the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// the two front cells stay in order
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> ($signed(cell_key[0]) >= $signed(cell_key[1])))
		else $error("front cells out of order");

	// an insert with room is reported as inserted on the next cycle
	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == mhpq_pkg::CMD_INSERT && !full)
		|=> (m_tvalid && m_tuser == mhpq_pkg::ST_INSERTED))
		else $error("insert with room not reported as inserted");

	// an empty extract leaves nothing and returns zero
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == mhpq_pkg::ST_EMPTY)
		|-> (m_tdata == '0 && count_q == '0))
		else $error("empty extract with non-zero result");
`endif

endmodule
